// ===== rtl/mm1q_pkg.sv =====
// Shared types and fixed widths of the M/M/1 queue event simulator.
package mm1q_pkg;

  localparam int SAMPLE_W = 32;
  localparam int STAT_W   = 64;
  localparam int COUNT_W  = 32;

  localparam logic ACTION_START = 1'b0;

  typedef enum logic [1:0] {
    KIND_START     = 2'd0,
    KIND_ARRIVAL   = 2'd1,
    KIND_DEPARTURE = 2'd2
  } event_kind_t;

endpackage

// ===== rtl/mm1_queue_event_simulator.sv =====
// Single-server FIFO queue simulator: one event per item, arrival stamps held in a memory.
//
// Each transfer in either starts a new run (action 0) or processes the earlier of the pending
// arrival and departure, departure first on a tie. The block takes a new item only when its
// capture register is empty and the event ahead can move on, and the result passes the decision,
// statistics and output registers, later while the result side stalls; this pacing is set by
// the event decision, which reads the clock, the due times and the FIFO pointers committed by
// the previous event, followed by the registered read of the arrival stamp memory at the queue
// head. Queue area and wait totals are summed one stage later and do not hold up the next item.
// A finished result waits in the output register while the next item is taken in. The stamp
// memory needs no clearing after reset: only entries that were written are ever read. Times are
// Q32.FRACTION_BITS and saturate; statistics saturate at their field maximum; an arrival that
// finds a full FIFO is dropped, counted and flagged in the sticky overflow bit.
module mm1_queue_event_simulator import mm1q_pkg::*; #(
  parameter int QUEUE_DEPTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [SAMPLE_W-1:0]  interarrival_sample,
  input  logic [SAMPLE_W-1:0]  service_sample,

  output logic                 out_valid,
  input  logic                 out_ready,
  output event_kind_t          event_kind,
  output logic [31+FRACTION_BITS:0]           event_time,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_length,
  output logic                 server_busy,
  output logic [STAT_W-1:0]    queue_area,
  output logic [31+FRACTION_BITS:0]           busy_total,
  output logic [STAT_W-1:0]    wait_total,
  output logic [COUNT_W-1:0]   arrival_count,
  output logic                 overflow
);

  localparam int TIME_W  = 32 + FRACTION_BITS;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W   = (OCC_W + TIME_W > STAT_W) ? OCC_W + TIME_W : STAT_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_MAX  = OCC_W'(QUEUE_DEPTH);

  function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] t,
                                                  input logic [TIME_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {1'b0, d};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic logic [STAT_W-1:0] stat_add(input logic [STAT_W-1:0] a,
                                                  input logic [STAT_W-1:0] b);
    logic [STAT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[STAT_W] ? '1 : s[STAT_W-1:0];
  endfunction

  // Simulation state
  logic [TIME_W-1:0]  clock_now, arrival_due, departure_due;
  logic               busy_flag;
  logic [PTR_W-1:0]   head_pointer, tail_pointer;
  logic [OCC_W-1:0]   occupancy;
  logic [STAT_W-1:0]  area_sum, wait_sum;
  logic [TIME_W-1:0]  busy_sum;
  logic [COUNT_W-1:0] arrivals_seen;
  logic               dropped_flag;

  // Arrival stamp memory
  logic [TIME_W-1:0]  stamp_mem [QUEUE_DEPTH];
  logic [TIME_W-1:0]  stamp_rd;

  // Stage valids and handshake
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  // Stage 1: captured item
  logic                s1_action;
  logic [SAMPLE_W-1:0] s1_ia, s1_sv;

  // Stage 2: decided event
  logic                s2_start, s2_dep;
  logic [TIME_W-1:0]   s2_clock, s2_elapsed;
  logic [SAMPLE_W-1:0] s2_ia, s2_sv;

  // Stage 3: statistics update
  logic                s3_start;
  event_kind_t         s3_kind;
  logic [STAT_W-1:0]   s3_prod;
  logic [TIME_W-1:0]   s3_wait;

  assign adv3     = v3 && (!out_valid || out_ready);
  assign adv2     = v2 && (!v3 || adv3);
  assign adv1     = v1 && (!v2 || adv2);
  assign in_ready = !v1 && (!v2 || adv2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) v1 <= 1'b1;
      else if (adv1)            v1 <= 1'b0;
      if (adv1)      v2 <= 1'b1;
      else if (adv2) v2 <= 1'b0;
      if (adv2)      v3 <= 1'b1;
      else if (adv3) v3 <= 1'b0;
      if (adv3)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_ia     <= interarrival_sample;
      s1_sv     <= service_sample;
    end
  end

  // Stage 1: pick the next event and the time that elapses up to it
  logic              dep_first;
  logic [TIME_W-1:0] next_time;
  logic [TIME_W:0]   gap;

  always_comb begin
    dep_first = busy_flag && (departure_due <= arrival_due);
    next_time = dep_first ? departure_due : arrival_due;
    gap       = {1'b0, next_time} - {1'b0, clock_now};
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_start   <= (s1_action == ACTION_START);
      s2_dep     <= dep_first;
      s2_clock   <= gap[TIME_W] ? clock_now : next_time;
      s2_elapsed <= gap[TIME_W] ? '0 : gap[TIME_W-1:0];
      s2_ia      <= s1_ia;
      s2_sv      <= s1_sv;
    end
  end

  // Stage 2: commit the event to the simulation state
  logic [TIME_W-1:0]  clock_next, arrival_due_next, departure_due_next, busy_sum_next;
  logic               busy_flag_next, dropped_flag_next, push, pop;
  logic [PTR_W-1:0]   head_next, tail_next;
  logic [OCC_W-1:0]   occupancy_next;
  logic [COUNT_W-1:0] arrivals_next;
  logic [TIME_W-1:0]  wait_delta;
  logic [TIME_W:0]    wait_gap, busy_acc;
  logic [EXT_W-1:0]   prod_ext;
  event_kind_t        kind_next;

  always_comb begin
    clock_next         = s2_clock;
    arrival_due_next   = arrival_due;
    departure_due_next = departure_due;
    busy_flag_next     = busy_flag;
    head_next          = head_pointer;
    tail_next          = tail_pointer;
    occupancy_next     = occupancy;
    arrivals_next      = arrivals_seen;
    dropped_flag_next  = dropped_flag;
    busy_sum_next      = busy_sum;
    push               = 1'b0;
    pop                = 1'b0;
    wait_delta         = '0;
    kind_next          = KIND_ARRIVAL;

    busy_acc = {1'b0, busy_sum} + {1'b0, s2_elapsed};
    wait_gap = {1'b0, s2_clock} - {1'b0, stamp_rd};
    prod_ext = EXT_W'(occupancy) * EXT_W'(s2_elapsed);

    if (s2_start) begin
      kind_next          = KIND_START;
      clock_next         = '0;
      arrival_due_next   = TIME_W'(s2_ia);
      departure_due_next = '0;
      busy_flag_next     = 1'b0;
      head_next          = '0;
      tail_next          = '0;
      occupancy_next     = '0;
      arrivals_next      = '0;
      dropped_flag_next  = 1'b0;
      busy_sum_next      = '0;
    end else begin
      if (busy_flag) busy_sum_next = busy_acc[TIME_W] ? '1 : busy_acc[TIME_W-1:0];
      if (!s2_dep) begin
        if (!busy_flag) begin
          busy_flag_next     = 1'b1;
          departure_due_next = time_add(s2_clock, TIME_W'(s2_sv));
        end else if (occupancy < OCC_MAX) begin
          push           = 1'b1;
          tail_next      = (tail_pointer == PTR_LAST) ? '0 : tail_pointer + 1'b1;
          occupancy_next = occupancy + 1'b1;
        end else begin
          dropped_flag_next = 1'b1;
        end
        if (arrivals_seen != '1) arrivals_next = arrivals_seen + 1'b1;
        arrival_due_next = time_add(s2_clock, TIME_W'(s2_ia));
      end else begin
        kind_next = KIND_DEPARTURE;
        if (occupancy == '0) begin
          busy_flag_next = 1'b0;
        end else begin
          pop                = 1'b1;
          head_next          = (head_pointer == PTR_LAST) ? '0 : head_pointer + 1'b1;
          occupancy_next     = occupancy - 1'b1;
          departure_due_next = time_add(s2_clock, TIME_W'(s2_sv));
        end
      end
    end
    if (pop && !wait_gap[TIME_W]) wait_delta = wait_gap[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_now     <= '0;
      arrival_due   <= '0;
      departure_due <= '0;
      busy_flag     <= 1'b0;
      head_pointer  <= '0;
      tail_pointer  <= '0;
      occupancy     <= '0;
      busy_sum      <= '0;
      arrivals_seen <= '0;
      dropped_flag  <= 1'b0;
    end else if (adv2) begin
      clock_now     <= clock_next;
      arrival_due   <= arrival_due_next;
      departure_due <= departure_due_next;
      busy_flag     <= busy_flag_next;
      head_pointer  <= head_next;
      tail_pointer  <= tail_next;
      occupancy     <= occupancy_next;
      busy_sum      <= busy_sum_next;
      arrivals_seen <= arrivals_next;
      dropped_flag  <= dropped_flag_next;
    end
  end

  // Stamp memory: write the queue tail, read the queue head every cycle
  always_ff @(posedge clk) begin
    if (adv2 && push) stamp_mem[tail_pointer] <= s2_clock;
    stamp_rd <= stamp_mem[head_pointer];
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_start <= s2_start;
      s3_kind  <= kind_next;
      s3_prod  <= (|prod_ext[EXT_W-1:STAT_W]) ? '1 : prod_ext[STAT_W-1:0];
      s3_wait  <= wait_delta;
    end
  end

  // Stage 3: accumulate area and waiting time, load the result
  logic [STAT_W-1:0] area_next, wait_next;

  always_comb begin
    area_next = s3_start ? '0 : stat_add(area_sum, s3_prod);
    wait_next = s3_start ? '0 : stat_add(wait_sum, STAT_W'(s3_wait));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_sum <= '0;
      wait_sum <= '0;
    end else if (adv3) begin
      area_sum <= area_next;
      wait_sum <= wait_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      event_kind    <= s3_kind;
      event_time    <= clock_now;
      queue_length  <= occupancy;
      server_busy   <= busy_flag;
      queue_area    <= area_next;
      busy_total    <= busy_sum;
      wait_total    <= wait_next;
      arrival_count <= arrivals_seen;
      overflow      <= dropped_flag;
    end
  end

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_MAX)
    else $error("queue occupancy beyond depth");

  a_pointer_match: assert property (@(posedge clk) disable iff (rst)
    (head_pointer == tail_pointer) |-> (occupancy == '0 || occupancy == OCC_MAX))
    else $error("head and tail agree but queue is neither empty nor full");

  a_clock_order: assert property (@(posedge clk) disable iff (rst)
    (clock_now <= arrival_due) && (!busy_flag || clock_now <= departure_due))
    else $error("simulation clock ahead of a pending event");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken before the event was decided");

endmodule

// ===== tb/tb.sv =====
// Testbench for the M/M/1 queue event simulator: directed table, then random runs on a queue model.
`timescale 1ns / 1ps

module tb import mm1q_pkg::*; ();

  localparam int QDEPTH      = 1024;
  localparam int FRAC        = 16;
  localparam int TW          = 32 + FRAC;
  localparam int QW          = $clog2(QDEPTH + 1);
  localparam int ITEM_TARGET = 1450;
  localparam int FILL_AFTER  = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN       = 8;

  localparam logic ACTION_EVENT = ~ACTION_START;

  typedef struct packed {
    event_kind_t      kind;
    logic [TW-1:0]    evt_time;
    logic [QW-1:0]    qlen;
    logic             busy;
    logic [STAT_W-1:0] area;
    logic [TW-1:0]    busy_time;
    logic [STAT_W-1:0] wait_time;
    logic [COUNT_W-1:0] arrivals;
    logic             dropped;
  } result_t;

  typedef struct packed {
    logic              act;
    logic [SAMPLE_W-1:0] ia;
    logic [SAMPLE_W-1:0] sv;
    logic              typed;
    result_t           want;
  } plan_row_t;

  typedef enum int {LOAD_HEAVY, LOAD_LIGHT, LOAD_EVEN, LOAD_WIDE} load_t;

  // a start reports kind start with every other field cleared
  localparam result_t START_REPORT = '0;

  localparam int PLAN_LEN = 20;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // event before any start: arrival at time zero on the reset state
    '{ACTION_EVENT, 32'h0005_0000, 32'h0003_0000, 1'b1,
      '{KIND_ARRIVAL, 48'h0, 11'd0, 1'b1, 64'h0, 48'h0, 64'h0, 32'd1, 1'b0}},
    '{ACTION_START, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, START_REPORT},
    '{ACTION_EVENT, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{KIND_ARRIVAL, 48'h0, 11'd0, 1'b1, 64'h0, 48'h0, 64'h0, 32'd1, 1'b0}},
    // tie at time zero: departure wins, empty queue so the server goes idle
    '{ACTION_EVENT, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{KIND_DEPARTURE, 48'h0, 11'd0, 1'b0, 64'h0, 48'h0, 64'h0, 32'd1, 1'b0}},
    '{ACTION_START, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, START_REPORT},
    '{ACTION_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{KIND_ARRIVAL, 48'h0000_FFFF_FFFF, 11'd0, 1'b1, 64'h0, 48'h0, 64'h0, 32'd1, 1'b0}},
    '{ACTION_EVENT, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{KIND_DEPARTURE, 48'h0001_FFFF_FFFE, 11'd0, 1'b0, 64'h0, 48'h0000_FFFF_FFFF,
        64'h0, 32'd1, 1'b0}},
    // idle server: a stale departure time must not count as pending
    '{ACTION_EVENT, 32'h0001_0000, 32'h0002_0000, 1'b0, '0},
    '{ACTION_EVENT, 32'h0000_8000, 32'h0000_4000, 1'b0, '0},
    '{ACTION_EVENT, 32'h0000_8000, 32'h0000_4000, 1'b0, '0},
    '{ACTION_EVENT, 32'h0000_8000, 32'h0001_8000, 1'b0, '0},
    '{ACTION_EVENT, 32'h0000_0001, 32'h0000_0001, 1'b0, '0},
    '{ACTION_EVENT, 32'h0000_0002, 32'h0000_0003, 1'b0, '0},
    // start while customers wait: everything clears
    '{ACTION_START, 32'h0000_0002, 32'h0000_0000, 1'b1, START_REPORT},
    '{ACTION_EVENT, 32'h0000_0003, 32'h8000_0000, 1'b0, '0},
    '{ACTION_EVENT, 32'h0000_0004, 32'h0000_0001, 1'b0, '0},
    '{ACTION_EVENT, 32'h1234_5678, 32'h7FFF_FFFF, 1'b0, '0},
    '{ACTION_EVENT, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b0, '0},
    '{ACTION_EVENT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ACTION_EVENT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                action = ACTION_START;
  logic [SAMPLE_W-1:0] interarrival_sample = '0;
  logic [SAMPLE_W-1:0] service_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  event_kind_t         event_kind;
  logic [TW-1:0]       event_time;
  logic [QW-1:0]       queue_length;
  logic                server_busy;
  logic [STAT_W-1:0]   queue_area;
  logic [TW-1:0]       busy_total;
  logic [STAT_W-1:0]   wait_total;
  logic [COUNT_W-1:0]  arrival_count;
  logic                overflow;

  mm1_queue_event_simulator #(
    .QUEUE_DEPTH  (QDEPTH),
    .FRACTION_BITS(FRAC)
  ) i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .interarrival_sample(interarrival_sample),
    .service_sample     (service_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_kind         (event_kind),
    .event_time         (event_time),
    .queue_length       (queue_length),
    .server_busy        (server_busy),
    .queue_area         (queue_area),
    .busy_total         (busy_total),
    .wait_total         (wait_total),
    .arrival_count      (arrival_count),
    .overflow           (overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // queue model state
  logic [TW-1:0]             sim_clock = '0;
  logic [TW-1:0]             arrival_at = '0;
  logic [TW-1:0]             departure_at = '0;
  bit                        in_service = 1'b0;
  logic [TW-1:0]             arrival_log [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] log_head = '0;
  logic [$clog2(QDEPTH)-1:0] log_tail = '0;
  int                        waiting = 0;
  logic [STAT_W-1:0]         area_acc = '0;
  logic [TW-1:0]             busy_acc = '0;
  logic [STAT_W-1:0]         wait_acc = '0;
  logic [COUNT_W-1:0]        arrivals_acc = '0;
  bit                        dropped_any = 1'b0;

  result_t event_reports [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      n_start = 0, n_arrive = 0, n_depart = 0, n_drop = 0, peak_waiting = 0;
  bit      send_calm = 1'b0;
  bit      recv_calm = 1'b0;

  function automatic logic [TW-1:0] add_time(input logic [TW-1:0] t, input logic [TW-1:0] d);
    logic [TW:0] s;
    s = {1'b0, t} + {1'b0, d};
    return s[TW] ? '1 : s[TW-1:0];
  endfunction

  function automatic logic [STAT_W-1:0] add_stat(input logic [STAT_W-1:0] a,
                                                 input logic [STAT_W-1:0] b);
    logic [STAT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[STAT_W] ? '1 : s[STAT_W-1:0];
  endfunction

  // advance the queue model by one item and return the report it should produce
  function automatic result_t next_queue_event(input logic act, input logic [SAMPLE_W-1:0] ia,
                                               input logic [SAMPLE_W-1:0] sv);
    result_t       r;
    event_kind_t   kind;
    bit            departs;
    logic [TW-1:0] due;
    logic [TW-1:0] elapsed;
    logic [TW-1:0] stamp;
    if (act == ACTION_START) begin
      sim_clock      = '0;
      departure_at   = '0;
      in_service     = 1'b0;
      log_head       = '0;
      log_tail       = '0;
      waiting        = 0;
      area_acc       = '0;
      busy_acc       = '0;
      wait_acc       = '0;
      arrivals_acc   = '0;
      dropped_any    = 1'b0;
      arrival_at     = add_time('0, TW'(ia));
      kind           = KIND_START;
      n_start++;
    end else begin
      departs = in_service && (departure_at <= arrival_at);
      due     = departs ? departure_at : arrival_at;
      elapsed = (due > sim_clock) ? due - sim_clock : '0;
      // occupancy times a 48-bit interval fits well inside 64 bits
      area_acc = add_stat(area_acc, 64'(waiting) * 64'(elapsed));
      if (in_service) busy_acc = add_time(busy_acc, elapsed);
      if (due > sim_clock) sim_clock = due;
      if (!departs) begin
        kind = KIND_ARRIVAL;
        n_arrive++;
        if (!in_service) begin
          in_service   = 1'b1;
          departure_at = add_time(sim_clock, TW'(sv));
        end else if (waiting < QDEPTH) begin
          arrival_log[log_tail] = sim_clock;
          log_tail++;
          waiting++;
        end else begin
          dropped_any = 1'b1;
          n_drop++;
        end
        if (arrivals_acc != '1) arrivals_acc++;
        arrival_at = add_time(sim_clock, TW'(ia));
      end else begin
        kind = KIND_DEPARTURE;
        n_depart++;
        if (waiting == 0) begin
          in_service = 1'b0;
        end else begin
          stamp = arrival_log[log_head];
          log_head++;
          waiting--;
          wait_acc     = add_stat(wait_acc, (sim_clock > stamp) ? 64'(sim_clock - stamp) : '0);
          departure_at = add_time(sim_clock, TW'(sv));
        end
      end
    end
    if (waiting > peak_waiting) peak_waiting = waiting;
    r.kind      = kind;
    r.evt_time  = sim_clock;
    r.qlen      = QW'(waiting);
    r.busy      = in_service;
    r.area      = area_acc;
    r.busy_time = busy_acc;
    r.wait_time = wait_acc;
    r.arrivals  = arrivals_acc;
    r.dropped   = dropped_any;
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(19, 0));
  endfunction

  function automatic void pick_samples(input load_t load, output logic [SAMPLE_W-1:0] ia,
                                       output logic [SAMPLE_W-1:0] sv);
    case (load)
      LOAD_HEAVY: begin
        ia = $urandom_range(32'h0002_0000, 0);
        sv = $urandom_range(32'h0008_0000, 32'h0001_0000);
      end
      LOAD_LIGHT: begin
        ia = $urandom_range(32'h0010_0000, 32'h0001_0000);
        sv = $urandom_range(32'h0002_0000, 0);
      end
      LOAD_EVEN: begin
        ia = $urandom_range(32'h0004_0000, 0);
        sv = $urandom_range(32'h0004_0000, 0);
      end
      default: begin
        ia = $urandom();
        sv = $urandom();
      end
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] ia,
                           input logic [SAMPLE_W-1:0] sv, input bit typed,
                           input result_t typed_want);
    int      gap;
    result_t pred;
    gap = pick_gap(send_calm);
    if ($urandom_range(31, 0) == 0) send_calm = !send_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    action              <= act;
    interarrival_sample <= ia;
    service_sample      <= sv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = next_queue_event(act, ia, sv);
    event_reports.push_back(typed ? typed_want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_event(input load_t load);
    logic [SAMPLE_W-1:0] ia, sv;
    logic                act;
    act = ACTION_EVENT;
    pick_samples(load, ia, sv);
    // now and then a stray item: a start in mid-run or full-range samples
    if ($urandom_range(15, 0) == 0) begin
      act = logic'($urandom_range(1, 0));
      ia  = $urandom();
      sv  = $urandom();
    end
    send_item(act, ia, sv, 1'b0, '0);
  endtask

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_report(input result_t got);
    result_t want;
    if (event_reports.size() == 0) begin
      $error("report with no item pending: kind %0d, time %h", got.kind, got.evt_time);
      mismatch_count++;
    end else begin
      want = event_reports.pop_front();
      check_field("event_kind", 64'(want.kind), 64'(got.kind));
      check_field("event_time", 64'(want.evt_time), 64'(got.evt_time));
      check_field("queue_length", 64'(want.qlen), 64'(got.qlen));
      check_field("server_busy", 64'(want.busy), 64'(got.busy));
      check_field("queue_area", want.area, got.area);
      check_field("busy_total", 64'(want.busy_time), 64'(got.busy_time));
      check_field("wait_total", want.wait_time, got.wait_time);
      check_field("arrival_count", 64'(want.arrivals), 64'(got.arrivals));
      check_field("overflow", 64'(want.dropped), 64'(got.dropped));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      check_report(result_t'{event_kind, event_time, queue_length, server_busy, queue_area,
                             busy_total, wait_total, arrival_count, overflow});
  end

  // result side: hold off for a random number of cycles before each transfer
  initial begin : report_sink
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = pick_gap(recv_calm);
      if ($urandom_range(31, 0) == 0) recv_calm = !recv_calm;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // worst quiet stretch is the longest send gap plus the longest result stall plus the pipeline passage
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $error("no transfer for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    load_t               load;
    int                  run_len;
    bit                  fill_done;
    logic [SAMPLE_W-1:0] ia, sv;
    fill_done = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++)
      send_item(PLAN[i].act, PLAN[i].ia, PLAN[i].sv, PLAN[i].typed, PLAN[i].want);

    while (items_sent < ITEM_TARGET) begin
      if (!fill_done && items_sent >= FILL_AFTER) begin
        // one long service with tight arrivals: fill the queue, then drop on the full queue
        fill_done = 1'b1;
        send_item(ACTION_START, $urandom_range(255, 0), $urandom(), 1'b0, '0);
        repeat (QDEPTH + 16) begin
          ia = $urandom_range(255, 0);
          sv = {16'hFFFF, 16'($urandom())};
          send_item(ACTION_EVENT, ia, sv, 1'b0, '0);
        end
        repeat (20) send_event(LOAD_WIDE);
      end else begin
        load    = load_t'($urandom_range(3, 0));
        run_len = $urandom_range(40, 5);
        pick_samples(load, ia, sv);
        send_item(ACTION_START, ia, sv, 1'b0, '0);
        repeat (run_len) send_event(load);
      end
    end
    in_valid <= 1'b0;

    while (event_reports.size() != 0) @(posedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("%0d items: %0d starts, %0d arrivals (%0d dropped at a full queue), %0d departures",
             items_sent, n_start, n_arrive, n_drop, n_depart);
    $display("deepest queue %0d of %0d customers", peak_waiting, QDEPTH);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mm1q_pkg.sv
rtl/mm1_queue_event_simulator.sv
tb/tb.sv
